FILE: hdl/mfdu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motor feedback decode package
// Shared types, register codes and fixed constants of the motor feedback
// decoder with multi-turn unwrap.
// ----------------------------------------------------------------------------
package mfdu_pkg;

  localparam int unsigned COUNTS_PER_TURN = 8192;
  localparam int unsigned ANGLE_FRAC_BITS = 16;
  localparam int unsigned RECIP_SHIFT     = 16;

  localparam int unsigned ID_W    = 11;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned ANGLE_W = 40;
  localparam int unsigned KIND_W  = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_KIND  = 2'd2;

  localparam logic [ID_W-1:0]   MOTOR_ID_RESET   = 11'd517;
  localparam logic              BUS_SELECT_RESET = 1'b0;

  localparam logic [KIND_W-1:0] GEAR_DIRECT = 2'd0;
  localparam logic [KIND_W-1:0] GEAR_36     = 2'd1;
  localparam logic [KIND_W-1:0] GEAR_B      = 2'd2;
  localparam logic [KIND_W-1:0] GEAR_UNUSED = 2'd3;

  localparam logic [63:0] ANGLE_MIN_MAG = 64'd549755813888;
  localparam logic [63:0] ANGLE_MAX_MAG = 64'd549755813887;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef struct packed {
    logic              bus_index;
    logic [ID_W-1:0]   frame_id;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic [BYTE_W-1:0] byte3;
    logic [BYTE_W-1:0] byte4;
    logic [BYTE_W-1:0] byte5;
    logic [BYTE_W-1:0] byte6;
  } mfdu_frame_t;

  typedef struct packed {
    logic [POS_W-1:0]          position;
    logic signed [WORD_W-1:0]  speed;
    logic signed [WORD_W-1:0]  drive_current;
    logic [BYTE_W-1:0]         temp_reading;
    logic signed [SUM_W-1:0]   turn_total;
    logic signed [ANGLE_W-1:0] angle_fixed;
  } mfdu_result_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] speed;
    logic signed [WORD_W-1:0] drive_current;
    logic [BYTE_W-1:0]        temp_reading;
  } mfdu_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mfdu_qstat_t;

endpackage
`default_nettype wire

FILE: hdl/mfdu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motor feedback decode front end
// Filters received frames on bus and identifier and unpacks a matching
// frame into an item for the queue.
// ----------------------------------------------------------------------------
module mfdu_front
  import mfdu_pkg::*;
(
  input  wire mfdu_frame_t       frame,
  input  wire                    frame_valid,
  output logic                   frame_stall,
  input  wire [ID_W-1:0]         motor_id,
  input  wire                    bus_select,
  input  wire [KIND_W-1:0]       gear_kind,
  input  wire mfdu_qstat_t       qstat,
  output logic                   push,
  output mfdu_item_t             item
);

  logic match;
  logic [WORD_W-1:0] enc;

  assign frame_stall = qstat.full;
  assign match = (frame.bus_index == bus_select) && (frame.frame_id == motor_id);
  assign push  = frame_valid && !qstat.full && match;

  assign enc = {frame.byte0, frame.byte1};

  always_comb begin
    item.kind          = gear_kind;
    item.position      = enc[POS_W-1:0];
    item.speed         = $signed({frame.byte2, frame.byte3});
    item.drive_current = $signed({frame.byte4, frame.byte5});
    item.temp_reading  = frame.byte6;
  end

endmodule
`default_nettype wire

FILE: hdl/mfdu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motor feedback decode item queue
// Short register queue that lets the front end and the back end stall
// independently of each other.
// ----------------------------------------------------------------------------
module mfdu_queue
  import mfdu_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire mfdu_item_t  push_item,
  input  wire              pop,
  output mfdu_item_t       head,
  output mfdu_qstat_t      qstat
);

  mfdu_item_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              do_push;
  logic              do_pop;

  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push = push && !qstat.full;
  assign do_pop  = pop && !qstat.empty;
  assign head = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mfdu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motor feedback decode back end
// Unwraps geared encoder steps into the saturating turn accumulator, scales
// it or the direct position to a fixed-point angle over a four-stage pipeline.
// ----------------------------------------------------------------------------
module mfdu_back
  import mfdu_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = mfdu_pkg::ANGLE_FRAC_BITS
)
(
  input  wire              clk,
  input  wire              rst,
  input  wire              item_valid,
  input  wire mfdu_item_t  item,
  output logic             pop,
  output logic             result_valid,
  input  wire              result_stall,
  output mfdu_result_t     result
);

  localparam int unsigned M_W    = ANGLE_FRAC_BITS + 12;
  localparam int unsigned P_W    = SUM_W + M_W;
  localparam int unsigned RND_W  = P_W - RECIP_SHIFT + 1;
  localparam int unsigned STEP_W = POS_W + 2;

  localparam logic [63:0] M_DIRECT_64 =
    (((64'd360 << (ANGLE_FRAC_BITS + RECIP_SHIFT)) * 64'd2) / 64'(COUNTS_PER_TURN)
     + 64'd1) / 64'd2;
  localparam logic [63:0] M_GEAR36_64 =
    (((64'd10 << (ANGLE_FRAC_BITS + RECIP_SHIFT)) * 64'd2) / 64'(COUNTS_PER_TURN)
     + 64'd1) / 64'd2;
  localparam logic [63:0] M_GEARB_64 =
    (((64'd67320 << (ANGLE_FRAC_BITS + RECIP_SHIFT)) * 64'd2)
     / (64'(COUNTS_PER_TURN) * 64'd3591) + 64'd1) / 64'd2;

  localparam logic [M_W-1:0] M_DIRECT = M_W'(M_DIRECT_64);
  localparam logic [M_W-1:0] M_GEAR36 = M_W'(M_GEAR36_64);
  localparam logic [M_W-1:0] M_GEARB  = M_W'(M_GEARB_64);

  localparam logic signed [STEP_W-1:0] TURN = STEP_W'(COUNTS_PER_TURN);
  localparam logic signed [STEP_W-1:0] HALF = STEP_W'(COUNTS_PER_TURN / 2);
  localparam logic [P_W:0] ROUND_HALF = (P_W + 1)'(64'd1 << (RECIP_SHIFT - 1));

  // Unwrap state.
  logic [POS_W-1:0]        prev_position;
  logic signed [SUM_W-1:0] count_sum;
  logic [POS_W-1:0]        prev_position_next;
  logic signed [SUM_W-1:0] count_sum_next;

  // Stage valids and pipeline flow.
  logic a_v, b_v, c_v;
  logic a_ready, b_ready, c_ready, d_ready;

  // Stage A: item, value to scale and accumulator after the item.
  mfdu_item_t              a_item;
  logic signed [SUM_W-1:0] a_val;
  logic signed [SUM_W-1:0] a_turn;
  // Stage B: magnitude and scale factor.
  mfdu_item_t              b_item;
  logic signed [SUM_W-1:0] b_turn;
  logic                    b_neg;
  logic [SUM_W-1:0]        b_mag;
  logic [M_W-1:0]          b_m;
  // Stage C: product.
  mfdu_item_t              c_item;
  logic signed [SUM_W-1:0] c_turn;
  logic                    c_neg;
  logic [P_W-1:0]          c_prod;

  logic signed [STEP_W-1:0] diff;
  logic signed [STEP_W-1:0] step;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_sat;
  logic                     geared;
  logic signed [SUM_W-1:0]  a_val_next;

  logic                     b_neg_next;
  logic [SUM_W-1:0]         b_mag_next;
  logic [M_W-1:0]           b_m_next;

  logic [P_W:0]             rsum;
  logic [RND_W-1:0]         rnd;
  logic [ANGLE_W-1:0]       rnd_trunc;
  logic signed [ANGLE_W-1:0] angle_next;

  assign d_ready = !result_valid || !result_stall;
  assign c_ready = !c_v || d_ready;
  assign b_ready = !b_v || c_ready;
  assign a_ready = !a_v || b_ready;
  assign pop     = item_valid && a_ready;

  always_comb begin
    diff = $signed({2'b00, item.position}) - $signed({2'b00, prev_position});
    if (diff > HALF) begin
      step = diff - TURN;
    end else if (diff < -HALF) begin
      step = diff + TURN;
    end else begin
      step = diff;
    end
    sum_wide = {count_sum[SUM_W-1], count_sum}
             + {{(SUM_W + 1 - STEP_W){step[STEP_W-1]}}, step};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    geared = (item.kind == GEAR_36) || (item.kind == GEAR_B);
    count_sum_next     = geared ? sum_sat : count_sum;
    prev_position_next = geared ? item.position : prev_position;
    if (item.kind == GEAR_DIRECT) begin
      a_val_next = $signed(SUM_W'(item.position));
    end else begin
      a_val_next = count_sum_next;
    end
  end

  always_comb begin
    b_neg_next = a_val[SUM_W-1];
    b_mag_next = b_neg_next ? SUM_W'(-a_val) : SUM_W'(a_val);
    unique case (a_item.kind)
      GEAR_DIRECT: b_m_next = M_DIRECT;
      GEAR_36:     b_m_next = M_GEAR36;
      GEAR_B:      b_m_next = M_GEARB;
      GEAR_UNUSED: b_m_next = '0;
      default:     b_m_next = '0;
    endcase
  end

  always_comb begin
    rsum      = {1'b0, c_prod} + ROUND_HALF;
    rnd       = rsum[P_W:RECIP_SHIFT];
    rnd_trunc = ANGLE_W'(64'(rnd));
    if (c_neg) begin
      if (64'(rnd) >= ANGLE_MIN_MAG) begin
        angle_next = $signed(ANGLE_W'(ANGLE_MIN_MAG));
      end else begin
        angle_next = $signed(ANGLE_W'(-rnd_trunc));
      end
    end else begin
      if (64'(rnd) > ANGLE_MAX_MAG) begin
        angle_next = $signed(ANGLE_W'(ANGLE_MAX_MAG));
      end else begin
        angle_next = $signed(rnd_trunc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_position <= '0;
      count_sum     <= '0;
      a_v           <= 1'b0;
      b_v           <= 1'b0;
      c_v           <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (pop) begin
        prev_position <= prev_position_next;
        count_sum     <= count_sum_next;
      end
      if (a_ready) begin
        a_v <= item_valid;
      end
      if (b_ready) begin
        b_v <= a_v;
      end
      if (c_ready) begin
        c_v <= b_v;
      end
      if (d_ready) begin
        result_valid <= c_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_item <= item;
      a_val  <= a_val_next;
      a_turn <= count_sum_next;
    end
    if (b_ready && a_v) begin
      b_item <= a_item;
      b_turn <= a_turn;
      b_neg  <= b_neg_next;
      b_mag  <= b_mag_next;
      b_m    <= b_m_next;
    end
    if (c_ready && b_v) begin
      c_item <= b_item;
      c_turn <= b_turn;
      c_neg  <= b_neg;
      c_prod <= P_W'(b_mag) * P_W'(b_m);
    end
    if (d_ready && c_v) begin
      result.position      <= c_item.position;
      result.speed         <= c_item.speed;
      result.drive_current <= c_item.drive_current;
      result.temp_reading  <= c_item.temp_reading;
      result.turn_total    <= c_turn;
      result.angle_fixed   <= angle_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/motor_feedback_decode_unwrap_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Motor feedback decode and multi-turn unwrap
// Decodes the feedback frames of one motor slot into position, speed,
// current, temperature, an accumulated turn count and an angle in degrees.
//
//   Port group     Direction  Handshake          Payload
//   frame          in         valid / stall      mfdu_frame_t
//   result         out        valid / stall      mfdu_result_t
//   cfg            in         valid / ready      index and data
//
// One frame is taken in every cycle while the queue is not full; a result
// passes the queue register, back-end stages A, B and C and the result
// register. Reset is synchronous and resets the configuration, the queue and
// the pipeline. A stalled result holds the back end; the queue keeps the
// front end taking frames until full, and unmatched frames are dropped.
// ----------------------------------------------------------------------------
module motor_feedback_decode_unwrap_core
  import mfdu_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = mfdu_pkg::ANGLE_FRAC_BITS
)
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   frame_valid,
  output logic                  frame_stall,
  input  wire mfdu_frame_t      frame,
  output logic                  result_valid,
  input  wire                   result_stall,
  output mfdu_result_t          result,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  logic [ID_W-1:0]   motor_id;
  logic              bus_select;
  logic [KIND_W-1:0] gear_kind;

  logic        push;
  logic        pop;
  mfdu_item_t  push_item;
  mfdu_item_t  head;
  mfdu_qstat_t qstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_id   <= MOTOR_ID_RESET;
      bus_select <= BUS_SELECT_RESET;
      gear_kind  <= GEAR_DIRECT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MOTOR_ID:   motor_id   <= cfg_data[ID_W-1:0];
        CFG_BUS_SELECT: bus_select <= cfg_data[0];
        CFG_GEAR_KIND:  gear_kind  <= cfg_data[KIND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mfdu_front u_front (
    .frame       (frame),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .motor_id    (motor_id),
    .bus_select  (bus_select),
    .gear_kind   (gear_kind),
    .qstat       (qstat),
    .push        (push),
    .item        (push_item)
  );

  mfdu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  mfdu_back #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (!qstat.empty),
    .item         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("Result valid after reset.");

  a_push_only_on_match: assert property (@(posedge clk) disable iff (rst)
    push |-> (frame.bus_index == bus_select) && (frame.frame_id == motor_id)
             && frame_valid)
    else $error("Queue push for a frame that does not match.");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("Queue push while full.");

endmodule
`default_nettype wire
